// ----- src/radio_link_ack_retry_engine_unit_assert.svh -----
// ============================================================================
// Assertion macros for the ack/retry link engine
// Shared immediate-style wrappers around concurrent assertions.
// ============================================================================
`ifndef RADIO_LINK_ACK_RETRY_ENGINE_UNIT_ASSERT_SVH
`define RADIO_LINK_ACK_RETRY_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication: antecedent and consequent on the same edge.
`define RALE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rale assertion failed");

// Next-cycle implication.
`define RALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rale assertion failed");

`endif

// ----- src/rale_pkg.sv -----
// ============================================================================
// rale_pkg
// Types and constants shared by the ack/retry link engine.
// ============================================================================
`default_nettype none

package rale_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	// Header bit positions
	localparam int HDR_CTL_BIT = 7;
	localparam int HDR_DST_BIT = 6;
	localparam int HDR_ACK_BIT = 5;

	localparam logic [9:0]  RSSI_OFFSET     = 10'd300;
	localparam logic [4:0]  OWN_NODE_RST    = 5'd1;
	localparam logic [15:0] RETRY_RST       = 16'd50;
	localparam logic [7:0]  LIMIT_RST       = 8'd8;

	typedef enum logic [1:0] {
		CMD_ENQUEUE = 2'd0,
		CMD_RAW     = 2'd1,
		CMD_RX      = 2'd2,
		CMD_POLL    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_OWN_NODE = 2'd0,
		CFG_RETRY    = 2'd1,
		CFG_LIMIT    = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [6:0]  packet_len;
		logic        ack_request;
		logic [7:0]  raw_header;
		logic [7:0]  payload_tag;
		logic [7:0]  frame_header;
		logic        crc_ok;
		logic [6:0]  frame_len;
		logic [7:0]  frame_first_byte;
		logic [9:0]  rssi_sample;
		logic        radio_ready;
		logic [31:0] now_ms;
	} in_item_t;

	typedef struct packed {
		logic       tx_valid;
		logic       tx_is_ack;
		logic [7:0] tx_header;
		logic [6:0] tx_len;
		logic [7:0] tx_tag;
		logic [7:0] tx_rssi_byte;
		logic       rx_delivered;
		logic [7:0] rx_module;
		logic [2:0] entries_queued;
		logic [7:0] peer_ack_rssi;
		logic       enqueue_dropped;
	} result_t;

	// One outgoing frame descriptor
	typedef struct packed {
		logic [7:0] header;
		logic [6:0] length;
		logic [7:0] tag;
	} q_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
	} q_ctl_t;

endpackage

`default_nettype wire

// ----- src/rale_queue.sv -----
// ============================================================================
// rale_queue
// Outgoing descriptor FIFO: append at the fill level, shift on pop, head at 0.
// ============================================================================
`default_nettype none

module rale_queue (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire rale_pkg::q_ctl_t            ctl,
	input  wire rale_pkg::q_entry_t          wr_entry,
	output rale_pkg::q_entry_t               head,
	output logic [rale_pkg::CNT_W-1:0]       count,
	output logic [rale_pkg::CNT_W-1:0]       count_next
);

	rale_pkg::q_entry_t entries_q [rale_pkg::QUEUE_DEPTH];
	logic [rale_pkg::CNT_W-1:0] count_q;

	assign count = count_q;
	assign head  = entries_q[0];

	// push and pop never come together; pop on an empty queue holds at zero
	always_comb begin
		count_next = count_q;
		if (ctl.push) begin
			count_next = count_q + rale_pkg::CNT_W'(1);
		end else if (ctl.pop && (count_q != '0)) begin
			count_next = count_q - rale_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			entries_q[count_q[rale_pkg::IDX_W-1:0]] <= wr_entry;
		end else if (ctl.pop) begin
			for (int i = 0; i < rale_pkg::QUEUE_DEPTH - 1; i++) begin
				entries_q[i] <= entries_q[i + 1];
			end
		end
	end

endmodule

`default_nettype wire

// ----- src/radio_link_ack_retry_engine_unit.sv -----
// ============================================================================
// radio_link_ack_retry_engine_unit
// Stop-and-wait link engine with acknowledgement, retry and a small send queue.
// ============================================================================
// Takes one command per cycle while busy is low (enqueue, raw enqueue,
// received frame, poll). Each accepted command yields exactly one result,
// shown with done high for a single cycle: the command is held in the input
// register, then one pass of decision logic writes the result register. The
// receiver cannot stall, so results must be taken as they appear. busy is high
// only in the first cycle after reset; configuration writes are always taken.
`default_nettype none

module radio_link_ack_retry_engine_unit (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	output logic                     busy,
	input  wire rale_pkg::in_item_t  item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [15:0]         cfg_data,
	output logic                     done,
	output rale_pkg::result_t        result
);

	logic busy_q;

	// Configuration
	logic [4:0]  own_node_q;
	logic [15:0] retry_q;
	logic [7:0]  limit_q;

	// Link state
	logic [7:0]  attempts_q, attempts_next;
	logic [31:0] last_send_q, last_send_next;
	logic [7:0]  pend_hdr_q, pend_hdr_next;
	logic [7:0]  pend_rssi_q, pend_rssi_next;
	logic [7:0]  rx_rssi_q, rx_rssi_next;
	logic [7:0]  peer_rssi_q, peer_rssi_next;

	// Pipeline
	rale_pkg::in_item_t item_s1;
	logic               valid_s1;
	rale_pkg::result_t  result_s2, res;
	logic               done_s2;

	// Queue
	rale_pkg::q_ctl_t              q_ctl;
	rale_pkg::q_entry_t            q_wr, q_head, send_src;
	logic [rale_pkg::CNT_W-1:0]    q_count, q_count_next;

	// Decision terms
	rale_pkg::cmd_t cmd;
	logic           enq_cmd, q_empty, q_full, ready;
	logic           last_try, send, snd_keep, time_ok;
	logic [7:0]     enq_hdr, snd_hdr, ack_hdr;
	logic [9:0]     rssi_diff;
	logic [7:0]     meas;
	logic [4:0]     src_node;

	assign busy      = busy_q;
	assign cfg_ready = 1'b1;
	assign done      = done_s2;
	assign result    = result_s2;

	rale_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (q_ctl),
		.wr_entry   (q_wr),
		.head       (q_head),
		.count      (q_count),
		.count_next (q_count_next)
	);

	always_comb begin
		cmd       = rale_pkg::cmd_t'(item_s1.command);
		enq_cmd   = (cmd == rale_pkg::CMD_ENQUEUE) || (cmd == rale_pkg::CMD_RAW);
		ready     = item_s1.radio_ready;
		q_empty   = (q_count == '0);
		q_full    = (q_count >= rale_pkg::CNT_W'(rale_pkg::QUEUE_DEPTH));
		enq_hdr   = (cmd == rale_pkg::CMD_ENQUEUE)
		          ? {2'b00, item_s1.ack_request, own_node_q} : item_s1.raw_header;
		q_wr      = '{header: enq_hdr, length: item_s1.packet_len, tag: item_s1.payload_tag};
		// An enqueue only sends when the queue was empty: the new frame is the head
		send_src  = enq_cmd ? q_wr : q_head;
		last_try  = ({1'b0, attempts_q} + 9'd1) >= {1'b0, limit_q};
		snd_hdr   = send_src.header;
		if (last_try) begin
			snd_hdr[rale_pkg::HDR_ACK_BIT] = 1'b0;
		end
		snd_keep  = snd_hdr[rale_pkg::HDR_ACK_BIT];
		time_ok   = item_s1.now_ms >= (last_send_q + {16'd0, retry_q});
		rssi_diff = item_s1.rssi_sample - rale_pkg::RSSI_OFFSET;
		meas      = rssi_diff[9:2];
		src_node  = item_s1.frame_header[4:0];
		ack_hdr   = (src_node == own_node_q) ? {3'b100, own_node_q} : {3'b110, src_node};

		send           = 1'b0;
		q_ctl          = '0;
		res            = '0;
		attempts_next  = attempts_q;
		last_send_next = last_send_q;
		pend_hdr_next  = pend_hdr_q;
		pend_rssi_next = pend_rssi_q;
		rx_rssi_next   = rx_rssi_q;
		peer_rssi_next = peer_rssi_q;

		if (valid_s1) begin
			unique case (cmd)
				rale_pkg::CMD_ENQUEUE, rale_pkg::CMD_RAW: begin
					if (q_full) begin
						res.enqueue_dropped = 1'b1;
					end else if (q_empty && ready) begin
						send       = 1'b1;
						// a frame sent without ACK request leaves at once
						q_ctl.push = snd_keep;
					end else begin
						q_ctl.push = 1'b1;
					end
				end
				rale_pkg::CMD_RX: begin
					if (item_s1.crc_ok) begin
						if (!item_s1.frame_header[rale_pkg::HDR_CTL_BIT]) begin
							rx_rssi_next = meas;
							if (item_s1.frame_header[rale_pkg::HDR_ACK_BIT]) begin
								pend_hdr_next  = ack_hdr;
								pend_rssi_next = meas;
							end
							res.rx_delivered = 1'b1;
							res.rx_module    = item_s1.frame_first_byte;
						end else if (!item_s1.frame_header[rale_pkg::HDR_ACK_BIT]) begin
							rx_rssi_next = meas;
							if ((src_node == own_node_q) && !q_empty && (attempts_q != '0)) begin
								peer_rssi_next = (item_s1.frame_len == 7'd1)
								               ? item_s1.frame_first_byte : 8'd0;
								q_ctl.pop      = 1'b1;
								attempts_next  = '0;
							end
						end
					end
				end
				rale_pkg::CMD_POLL: begin
					if ((pend_hdr_q != '0) && ready) begin
						res.tx_valid     = 1'b1;
						res.tx_is_ack    = 1'b1;
						res.tx_header    = pend_hdr_q;
						res.tx_len       = 7'd1;
						res.tx_rssi_byte = pend_rssi_q;
						pend_hdr_next    = '0;
						pend_rssi_next   = '0;
					end else if (ready && !q_empty && ((attempts_q == '0) || time_ok)) begin
						send = 1'b1;
					end
				end
				default: ;
			endcase

			if (send) begin
				res.tx_valid  = 1'b1;
				res.tx_header = snd_hdr;
				res.tx_len    = send_src.length;
				res.tx_tag    = send_src.tag;
				if (!snd_keep) begin
					q_ctl.pop     = !enq_cmd;
					attempts_next = '0;
				end else begin
					attempts_next  = attempts_q + 8'd1;
					last_send_next = item_s1.now_ms;
				end
			end

			res.entries_queued = 3'(q_count_next);
			res.peer_ack_rssi  = peer_rssi_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b1;
			valid_s1    <= 1'b0;
			done_s2     <= 1'b0;
			own_node_q  <= rale_pkg::OWN_NODE_RST;
			retry_q     <= rale_pkg::RETRY_RST;
			limit_q     <= rale_pkg::LIMIT_RST;
			attempts_q  <= '0;
			last_send_q <= '0;
			pend_hdr_q  <= '0;
			pend_rssi_q <= '0;
			rx_rssi_q   <= '0;
			peer_rssi_q <= '0;
		end else begin
			busy_q      <= 1'b0;
			valid_s1    <= start && !busy_q;
			done_s2     <= valid_s1;
			attempts_q  <= attempts_next;
			last_send_q <= last_send_next;
			pend_hdr_q  <= pend_hdr_next;
			pend_rssi_q <= pend_rssi_next;
			rx_rssi_q   <= rx_rssi_next;
			peer_rssi_q <= peer_rssi_next;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rale_pkg::CFG_OWN_NODE: own_node_q <= cfg_data[4:0];
					rale_pkg::CFG_RETRY:    retry_q    <= cfg_data;
					rale_pkg::CFG_LIMIT:    limit_q    <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// Payload registers: capture the beat, hold otherwise
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result_s2 <= res;
		end
	end

endmodule

`default_nettype wire

// ----- src/rale_checker.sv -----
// ============================================================================
// rale_checker
// Port-level checks of the ack/retry link engine, bound to the top level.
// ============================================================================
`default_nettype none

`include "radio_link_ack_retry_engine_unit_assert.svh"

module rale_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               start,
	input wire logic               busy,
	input wire logic               done,
	input wire rale_pkg::result_t  result
);

	// every accepted beat gives a result on done
	`RALE_ASSERT_IMPL(a_item_yields_result, clk, arst_n, start && !busy, ##2 done)

	`RALE_ASSERT_IMPL(a_result_has_item, clk, arst_n, done, $past(start && !busy, 2))

	// idle transmit fields stay zero
	`RALE_ASSERT_IMPL(a_no_tx_zero, clk, arst_n, done && !result.tx_valid, (result.tx_header == 8'd0) && (result.tx_len == 7'd0) && (result.tx_tag == 8'd0) && !result.tx_is_ack)

	`RALE_ASSERT_IMPL(a_ack_frame_shape, clk, arst_n, done && result.tx_is_ack, result.tx_valid && (result.tx_len == 7'd1) && (result.tx_tag == 8'd0) && result.tx_header[7])

	// a refused enqueue neither sends nor delivers
	`RALE_ASSERT_IMPL(a_drop_is_quiet, clk, arst_n, done && result.enqueue_dropped, !result.tx_valid && !result.rx_delivered)

endmodule

bind radio_link_ack_retry_engine_unit rale_checker u_rale_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

`default_nettype wire
